// ===== hdl/blm_pkg.sv =====
// Package for the beacon link quality monitor.
// Sizes, codes, record layout and controller/datapath command and status types.
// No dependencies.
`default_nettype none
package blm_pkg;

  localparam int PEERS   = 8;
  localparam int TX_RING = 32;
  localparam int PEER_W  = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int RING_W  = (TX_RING > 1) ? $clog2(TX_RING) : 1;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 160;
  localparam int CFG_W     = 24;

  localparam logic [1:0] REQ_RX     = 2'd0;
  localparam logic [1:0] REQ_REPORT = 2'd1;
  localparam logic [1:0] REQ_TX     = 2'd2;
  localparam logic [1:0] REQ_SNAP   = 2'd3;

  localparam logic [1:0] KIND_PEER   = 2'd0;
  localparam logic [1:0] KIND_TX     = 2'd1;
  localparam logic [1:0] KIND_SHADOW = 2'd2;
  localparam logic [1:0] KIND_SILENT = 2'd3;

  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_SHADOW_WIN = 2'd1;
  localparam logic [1:0] CFG_BEACON_PER = 2'd2;

  localparam int TOT_TX_ATT = 0;
  localparam int TOT_TX_ACK = 1;
  localparam int TOT_SH_E   = 2;
  localparam int TOT_SH_M   = 3;
  localparam int TOT_SI_E   = 4;
  localparam int TOT_SI_M   = 5;
  localparam int TOT_N      = 6;

  localparam logic [7:0]  NO_RSSI      = 8'h9C;
  localparam logic [31:0] NEVER_MS     = 32'd60000;
  localparam logic [9:0]  US_PER_MS    = 10'd1000;
  localparam logic [19:0] RST_WIN      = 20'd3000;
  localparam logic [23:0] RST_PERIOD   = 24'd100000;
  localparam int          DIV_DIGITS   = 3;
  localparam logic [26:0] RECIP_MS     = 27'd68719477;
  localparam int          RECIP_SH     = 36;

  typedef struct packed {
    logic        acked;
    logic [7:0]  report_pdr_q;
    logic [7:0]  report_rssi_dbm;
    logic [7:0]  report_peer;
    logic        rssi_present;
    logic [7:0]  rx_rssi;
    logic        is_beacon;
    logic [7:0]  seq;
    logic [7:0]  src_node;
    logic [47:0] time_us;
    logic [1:0]  req_type;
  } item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [5:0]  peer_index;
    logic [7:0]  peer_rssi_dbm;
    logic [31:0] count_a;
    logic [31:0] count_b;
    logic [31:0] heard_gap_ms;
    logic [7:0]  back_rssi;
    logic [7:0]  rev_pdr_q;
    logic [31:0] back_age;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic load;
    logic rx_store;
    logic rep_store;
    logic tx_store;
    logic scan_init;
    logic scan_step;
    logic tally;
    logic snap_init;
    logic div_start;
    logic div_sel;
    logic cap_heard;
    logic cap_rev;
    logic emit_peer;
    logic next_peer;
    logic emit_tot;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       src_ok;
    logic       beacon;
    logic       hit;
    logic       scan_last;
    logic       more;
    logic       div_done;
    logic       out_free;
    logic       last_peer;
    logic       tot_last;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/beacon_link_quality_monitor.sv =====
// Beacon link quality monitor, top level.
// Depends on blm_pkg, blm_ctrl and blm_dp (which holds blm_div).
//
// Usage:
//   Requests enter on the s_ group, one beat per request; s_tuser is the request
//   type. Frames, reverse reports and transmit completions produce no output.
//   A snapshot produces eleven records on the m_ group: one per peer, then the
//   tx, shadow and silent totals; m_tlast marks the silent totals record.
//   Configuration is written via cfg_we/cfg_index/cfg_data, only while idle: a user rule, unchecked by the block.
// Timing:
//   One request is worked on at a time; s_tready is high only while idle.
//   Report, transmit and non-beacon or ignored frame requests return to idle after
//   decode. A beacon frame then scans the ring max(gap, 1) times, each scan being
//   1 to 32 ring compares, one ring entry per cycle, then a tally; gap is the sequence step.
//   Snapshot: per peer, two divides by 1000 for the ages and one emit, then one
//   record each for the tx, shadow and silent totals.
// Reset clears tables, totals, ring and configuration to defaults.
// A stalled receiver holds the output record and the snapshot waits for it.
`default_nettype none
module beacon_link_quality_monitor import blm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // time_us, src_node, seq, is_beacon, rx_rssi, rssi_present, report_peer,
  // report_rssi_dbm, report_pdr_q, acked
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // req_type
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // peer_index, peer_rssi_dbm, count_a, count_b, heard_gap_ms, back_rssi,
  // rev_pdr_q, back_age
  output logic [M_TDATA_W-1:0]      m_tdata,
  // record_kind
  output logic [1:0]                m_tuser,
  output logic                      m_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  item_t   item;
  cmd_t    cmd;
  status_t status;
  rec_t    rec;

  assign item.req_type        = s_tuser;
  assign item.time_us         = s_tdata[47:0];
  assign item.src_node        = s_tdata[55:48];
  assign item.seq             = s_tdata[63:56];
  assign item.is_beacon       = s_tdata[64];
  assign item.rx_rssi         = s_tdata[72:65];
  assign item.rssi_present    = s_tdata[73];
  assign item.report_peer     = s_tdata[81:74];
  assign item.report_rssi_dbm = s_tdata[89:82];
  assign item.report_pdr_q    = s_tdata[97:90];
  assign item.acked           = s_tdata[98];

  assign m_tdata = {2'b00, rec.back_age, rec.rev_pdr_q, rec.back_rssi,
                    rec.heard_gap_ms, rec.count_b, rec.count_a, rec.peer_rssi_dbm,
                    rec.peer_index};
  assign m_tuser = rec.record_kind;
  assign m_tlast = rec.last;

  blm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  blm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_rec   (rec)
  );

endmodule
`default_nettype wire

// ===== hdl/blm_div.sv =====
// Divide of a 48-bit time difference by 1000 by reciprocal multiplication, one 16-bit digit at
// a time, each digit then checked back for its remainder. Depends on blm_pkg.
`default_nettype none
module blm_div import blm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [47:0] num;
  logic [9:0]  rem;
  logic [25:0] part;
  logic [25:0] part_q;
  logic [15:0] digit;
  logic [52:0] prod;
  logic [25:0] back;
  logic [1:0]  cnt;
  logic        phase;
  logic        busy;

  assign part = {rem, num[47:32]};
  assign prod = {27'd0, part} * {26'd0, RECIP_MS};
  assign back = part_q - ({10'd0, digit} * {16'd0, US_PER_MS});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num   <= dividend;
        rem   <= '0;
        cnt   <= '0;
        phase <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        phase <= !phase;
        if (!phase) begin
          part_q <= part;
          digit  <= prod[RECIP_SH+15:RECIP_SH];
        end else begin
          rem      <= back[9:0];
          num      <= {num[31:0], 16'd0};
          quotient <= {quotient[15:0], digit};
          cnt      <= cnt + 2'd1;
          if (cnt == 2'(DIV_DIGITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/blm_dp.sv =====
// Datapath: configuration, peer tables, transmit ring, totals and output register.
// Depends on blm_pkg and blm_div.
`default_nettype none
module blm_dp import blm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire item_t            in_item,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output rec_t                  out_rec
);

  item_t              it;
  logic [PEER_W-1:0]  pidx;
  logic [7:0]         node_id;
  logic [19:0]        win;
  logic [23:0]        period;

  logic [47:0]        ring     [TX_RING];
  logic [TX_RING-1:0] ring_vld;
  logic [RING_W-1:0]  ptr;

  logic [47:0] heard    [PEERS];
  logic [7:0]  lseq     [PEERS];
  logic [7:0]  prssi    [PEERS];
  logic [31:0] rx_ok    [PEERS];
  logic [31:0] rx_exp   [PEERS];
  logic [7:0]  rep_rssi [PEERS];
  logic [7:0]  rev_pdr  [PEERS];
  logic [47:0] rev_time [PEERS];
  logic [31:0] totals   [TOT_N];

  logic [47:0]       due;
  logic [7:0]        remain;
  logic              first;
  logic [RING_W-1:0] sidx;
  logic              shadow;
  logic [31:0]       age_h;
  logic [31:0]       age_r;
  logic [1:0]        tot_sel;

  logic        src_ok;
  logic [7:0]  gap;
  logic [47:0] w;
  logic [47:0] d;
  logic        hit;
  logic [47:0] then_t;
  logic [47:0] dividend;
  logic        div_done;
  logic [31:0] quotient;
  logic        out_free;
  logic [31:0] exp_b;

  assign src_ok   = it.src_node < 8'(PEERS);
  assign gap      = it.seq - lseq[pidx];
  assign w        = ring[sidx];
  assign d        = (due >= w) ? (due - w) : (w - due);
  assign hit      = ring_vld[sidx] && (w != '0) && (d <= {28'd0, win});
  assign then_t   = cmd.div_sel ? rev_time[pidx] : heard[pidx];
  assign dividend = it.time_us - then_t;
  assign out_free = !out_valid || out_ready;
  assign exp_b    = (rx_exp[pidx] == '0) ? 32'd1 : rx_exp[pidx];

  assign status.req       = it.req_type;
  assign status.src_ok    = src_ok;
  assign status.beacon    = it.is_beacon;
  assign status.hit       = hit;
  assign status.scan_last = sidx == RING_W'(TX_RING - 1);
  assign status.more      = remain != '0;
  assign status.div_done  = div_done;
  assign status.out_free  = out_free;
  assign status.last_peer = pidx == PEER_W'(PEERS - 1);
  assign status.tot_last  = tot_sel == KIND_SILENT;

  blm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id   <= '0;
      win       <= RST_WIN;
      period    <= RST_PERIOD;
      ring_vld  <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PEERS; i++) begin
        heard[i]    <= '0;
        lseq[i]     <= '0;
        prssi[i]    <= '0;
        rx_ok[i]    <= '0;
        rx_exp[i]   <= '0;
        rep_rssi[i] <= '0;
        rev_pdr[i]  <= '0;
        rev_time[i] <= '0;
      end
      for (int i = 0; i < TOT_N; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ID:    node_id <= cfg_data[7:0];
          CFG_SHADOW_WIN: win     <= cfg_data[19:0];
          CFG_BEACON_PER: period  <= cfg_data[23:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        it   <= in_item;
        pidx <= in_item.src_node[PEER_W-1:0];
      end

      if (cmd.rx_store) begin
        prssi[pidx] <= it.rssi_present ? it.rx_rssi : NO_RSSI;
        heard[pidx] <= it.time_us;
        if (it.is_beacon) begin
          lseq[pidx]   <= it.seq;
          rx_ok[pidx]  <= rx_ok[pidx] + 32'd1;
          rx_exp[pidx] <= rx_exp[pidx] + ((gap == '0) ? 32'd1 : 32'(gap));
        end
      end

      if (cmd.rep_store && src_ok && it.is_beacon && it.report_peer == node_id) begin
        rep_rssi[pidx] <= it.report_rssi_dbm;
        rev_pdr[pidx]  <= it.report_pdr_q;
        rev_time[pidx] <= it.time_us;
      end

      if (cmd.tx_store) begin
        totals[TOT_TX_ATT] <= totals[TOT_TX_ATT] + 32'd1;
        if (it.acked) begin
          totals[TOT_TX_ACK] <= totals[TOT_TX_ACK] + 32'd1;
        end
        ring[ptr]     <= it.time_us;
        ring_vld[ptr] <= 1'b1;
        ptr <= (ptr == RING_W'(TX_RING - 1)) ? '0 : ptr + RING_W'(1);
      end

      if (cmd.scan_init) begin
        due    <= it.time_us;
        remain <= (gap == '0) ? 8'd0 : gap - 8'd1;
        first  <= 1'b1;
        sidx   <= '0;
      end

      if (cmd.scan_step) begin
        sidx   <= sidx + RING_W'(1);
        shadow <= hit;
      end

      if (cmd.tally) begin
        if (shadow) begin
          totals[TOT_SH_E] <= totals[TOT_SH_E] + 32'd1;
          if (!first) totals[TOT_SH_M] <= totals[TOT_SH_M] + 32'd1;
        end else begin
          totals[TOT_SI_E] <= totals[TOT_SI_E] + 32'd1;
          if (!first) totals[TOT_SI_M] <= totals[TOT_SI_M] + 32'd1;
        end
        first  <= 1'b0;
        sidx   <= '0;
        due    <= due - {24'd0, period};
        if (remain != '0) remain <= remain - 8'd1;
      end

      if (cmd.snap_init) begin
        pidx    <= '0;
        tot_sel <= KIND_TX;
      end

      if (cmd.cap_heard) age_h <= (heard[pidx] == '0) ? NEVER_MS : quotient;
      if (cmd.cap_rev)   age_r <= (rev_time[pidx] == '0) ? NEVER_MS : quotient;

      if (cmd.emit_peer) begin
        out_valid             <= 1'b1;
        out_rec.record_kind   <= KIND_PEER;
        out_rec.peer_index    <= 6'(pidx);
        out_rec.peer_rssi_dbm <= prssi[pidx];
        out_rec.count_a       <= rx_ok[pidx];
        out_rec.count_b       <= exp_b;
        out_rec.heard_gap_ms  <= age_h;
        out_rec.back_rssi     <= rep_rssi[pidx];
        out_rec.rev_pdr_q     <= rev_pdr[pidx];
        out_rec.back_age      <= age_r;
        out_rec.last          <= 1'b0;
        rx_ok[pidx]           <= '0;
        rx_exp[pidx]          <= '0;
      end else if (cmd.emit_tot) begin
        out_valid             <= 1'b1;
        out_rec.record_kind   <= tot_sel;
        out_rec.peer_index    <= '0;
        out_rec.peer_rssi_dbm <= '0;
        out_rec.heard_gap_ms  <= '0;
        out_rec.back_rssi     <= '0;
        out_rec.rev_pdr_q     <= '0;
        out_rec.back_age      <= '0;
        out_rec.last          <= tot_sel == KIND_SILENT;
        case (tot_sel)
          KIND_TX: begin
            out_rec.count_a <= totals[TOT_TX_ATT];
            out_rec.count_b <= totals[TOT_TX_ACK];
          end
          KIND_SHADOW: begin
            out_rec.count_a <= totals[TOT_SH_E];
            out_rec.count_b <= totals[TOT_SH_M];
          end
          default: begin
            out_rec.count_a <= totals[TOT_SI_E];
            out_rec.count_b <= totals[TOT_SI_M];
          end
        endcase
        tot_sel <= tot_sel + 2'd1;
        if (tot_sel == KIND_SILENT) begin
          for (int i = 0; i < TOT_N; i++) begin
            totals[i] <= '0;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.next_peer) pidx <= pidx + PEER_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/blm_ctrl.sv =====
// Controller state machine: sequences decode, ring scans, age divides and record emission.
// Depends on blm_pkg.
`default_nettype none
module blm_ctrl import blm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_TALLY, S_H_START, S_H_WAIT,
    S_R_START, S_R_WAIT, S_EMIT_PEER, S_EMIT_TOT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (status.req)
          REQ_RX: begin
            if (status.src_ok) begin
              cmd.rx_store = 1'b1;
              if (status.beacon) begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
              end
            end
          end
          REQ_REPORT: cmd.rep_store = 1'b1;
          REQ_TX:     cmd.tx_store  = 1'b1;
          default: begin
            cmd.snap_init = 1'b1;
            state_next    = S_H_START;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.hit || status.scan_last) state_next = S_TALLY;
      end
      S_TALLY: begin
        cmd.tally  = 1'b1;
        state_next = status.more ? S_SCAN : S_IDLE;
      end
      S_H_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_H_WAIT;
      end
      S_H_WAIT: begin
        if (status.div_done) begin
          cmd.cap_heard = 1'b1;
          state_next    = S_R_START;
        end
      end
      S_R_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (status.div_done) begin
          cmd.cap_rev = 1'b1;
          state_next  = S_EMIT_PEER;
        end
      end
      S_EMIT_PEER: begin
        if (status.out_free) begin
          cmd.emit_peer = 1'b1;
          if (status.last_peer) begin
            state_next = S_EMIT_TOT;
          end else begin
            cmd.next_peer = 1'b1;
            state_next    = S_H_START;
          end
        end
      end
      S_EMIT_TOT: begin
        if (status.out_free) begin
          cmd.emit_tot = 1'b1;
          if (status.tot_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/blm_chk.sv =====
// Port-level checker for the beacon link quality monitor, bound to the top level.
// Depends on blm_pkg.
`default_nettype none
module blm_chk import blm_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [1:0]           s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [1:0]           m_tuser,
  input wire logic                 m_tlast
);

  a_snap_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_SNAP |=> !s_tready)
    else $error("input taken right after a snapshot request");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_SILENT)))
    else $error("tlast not on silent totals record");

  a_tot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PEER |-> m_tdata[13:0] == '0)
    else $error("totals record carries peer fields");

  a_exp_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PEER |-> m_tdata[77:46] != '0)
    else $error("peer record with zero expected count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

endmodule

bind beacon_link_quality_monitor blm_chk u_chk (.*);
`default_nettype wire
